FILE: sv/lrc_pkg.sv
// Shared types and constants for the LRC frame receiver.
// No dependencies; used by lrc_cfg_regs and lrc_frame_receiver.
package lrc_pkg;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'h0E;

    localparam logic [7:0] MIN_LENGTH_RESET  = 8'd3;
    localparam logic [7:0] MAX_COMMAND_RESET = 8'd15;

    // Register index, taken from paddr[2]
    localparam logic CFG_MIN_LENGTH  = 1'b0;
    localparam logic CFG_MAX_COMMAND = 1'b1;

    // Input op codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_REARM = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FINISH  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LEN_ERR = 3'd1,
        ST_CMD_ERR = 3'd2,
        ST_LRC_ERR = 3'd3,
        ST_EOP_ERR = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] min_length;
        logic [7:0] max_command;
    } lrc_cfg_t;

endpackage

FILE: sv/lrc_cfg_regs.sv
// APB register block for the LRC frame receiver: min_length and max_command.
// Depends on lrc_pkg.
module lrc_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output lrc_pkg::lrc_cfg_t cfg
);

    logic [7:0] min_length_reg;
    logic [7:0] max_command_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg  <= lrc_pkg::MIN_LENGTH_RESET;
            max_command_reg <= lrc_pkg::MAX_COMMAND_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                lrc_pkg::CFG_MIN_LENGTH:  min_length_reg  <= pwdata[7:0];
                lrc_pkg::CFG_MAX_COMMAND: max_command_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[2])
            lrc_pkg::CFG_MIN_LENGTH:  prdata = {24'd0, min_length_reg};
            lrc_pkg::CFG_MAX_COMMAND: prdata = {24'd0, max_command_reg};
            default: prdata = 32'd0;
        endcase
    end

    assign cfg.min_length  = min_length_reg;
    assign cfg.max_command = max_command_reg;

endmodule

FILE: sv/lrc_frame_receiver.sv
// Top level of the LRC frame receiver: input register, deframing state, result register.
// Depends on lrc_pkg and lrc_cfg_regs.

// Takes one request per clock while the output does not stall: each byte or
// rearm request is captured in an input register; when the result register
// can advance, the deframer state is updated and any result (payload byte or
// frame-finished status) is loaded into the result register at that edge.
// s_axis_tready is low only while both the input register and the result
// register are full and m_axis_tready is low. Frames are AA AA LENG CMD
// ID_HI ID_LO payload LRC 0E with LENG - min_length payload bytes; after a
// good frame the receiver ignores bytes until a rearm request.
module lrc_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] op
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [2:0] status, [10:3] command,
                                        // [11] command_valid, [27:12] target_id,
                                        // [35:28] frame_length,
                                        // [43:36] payload_byte, [47:44] zero
    output logic [0:0]  m_axis_tuser    // [0] kind
);

    typedef enum logic [3:0] {
        PH_SOP1 = 4'd0,
        PH_SOP2 = 4'd1,
        PH_LENG = 4'd2,
        PH_CMD  = 4'd3,
        PH_IDHI = 4'd4,
        PH_IDLO = 4'd5,
        PH_DATA = 4'd6,
        PH_LRC  = 4'd7,
        PH_EOP  = 4'd8
    } phase_t;

    lrc_pkg::lrc_cfg_t cfg;

    lrc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // deframer state
    phase_t      phase_reg,      phase_next;
    logic [7:0]  lrc_reg,        lrc_next;
    logic [7:0]  held_length_reg, held_length_next;
    logic [7:0]  held_command_reg, held_command_next;
    logic [15:0] held_id_reg,    held_id_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic        frame_done_reg, frame_done_next;

    // result
    logic             res_valid;
    logic             res_kind;
    lrc_pkg::status_t res_status;
    logic [7:0]       res_command;
    logic             res_command_valid;
    logic [15:0]      res_id;
    logic [7:0]       res_length;
    logic [7:0]       res_payload;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [47:0] out_data_reg;

    logic       advance;
    logic       in_take;
    logic       do_clear;
    logic [7:0] b;
    logic [7:0] left_dec;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign b             = in_byte_reg;
    assign left_dec      = bytes_left_reg - 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= s_axis_tuser[0];
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        lrc_next          = lrc_reg;
        held_length_next  = held_length_reg;
        held_command_next = held_command_reg;
        held_id_next      = held_id_reg;
        bytes_left_next   = bytes_left_reg;
        frame_done_next   = frame_done_reg;
        do_clear          = 1'b0;

        res_valid         = 1'b0;
        res_kind          = lrc_pkg::KIND_FINISH;
        res_status        = lrc_pkg::ST_OK;
        res_command       = held_command_reg;
        res_command_valid = 1'b1;
        res_id            = held_id_reg;
        res_length        = held_length_reg;
        res_payload       = 8'd0;

        if (in_op_reg == lrc_pkg::OP_REARM)
        begin
            do_clear = 1'b1;
        end
        else if (!frame_done_reg)
        begin
            unique case (phase_reg)
                PH_SOP2:
                begin
                    if (b == lrc_pkg::START_BYTE)
                    begin
                        lrc_next   = 8'd0;
                        phase_next = PH_LENG;
                    end
                    else
                    begin
                        phase_next = PH_SOP1;
                    end
                end
                PH_LENG:
                begin
                    if (b < cfg.min_length)
                    begin
                        res_valid         = 1'b1;
                        res_status        = lrc_pkg::ST_LEN_ERR;
                        res_command       = 8'd0;
                        res_command_valid = 1'b0;
                        res_id            = 16'd0;
                        res_length        = b;
                        do_clear          = 1'b1;
                    end
                    else
                    begin
                        held_length_next = b;
                        lrc_next         = lrc_reg ^ b;
                        phase_next       = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    if (b > cfg.max_command)
                    begin
                        res_valid         = 1'b1;
                        res_status        = lrc_pkg::ST_CMD_ERR;
                        res_command       = 8'd0;
                        res_command_valid = 1'b0;
                        do_clear          = 1'b1;
                    end
                    else
                    begin
                        held_command_next = b;
                        lrc_next          = lrc_reg ^ b;
                        phase_next        = PH_IDHI;
                    end
                end
                PH_IDHI:
                begin
                    held_id_next = {b, 8'd0};
                    lrc_next     = lrc_reg ^ b;
                    phase_next   = PH_IDLO;
                end
                PH_IDLO:
                begin
                    held_id_next = {held_id_reg[15:8], b};
                    lrc_next     = lrc_reg ^ b;
                    // payload count follows min_length as it stands now
                    if (held_length_reg > cfg.min_length)
                    begin
                        bytes_left_next = held_length_reg - cfg.min_length;
                        phase_next      = PH_DATA;
                    end
                    else
                    begin
                        bytes_left_next = 8'd0;
                        phase_next      = PH_LRC;
                    end
                end
                PH_DATA:
                begin
                    lrc_next        = lrc_reg ^ b;
                    bytes_left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_LRC;
                    end
                    res_valid   = 1'b1;
                    res_kind    = lrc_pkg::KIND_PAYLOAD;
                    res_payload = b;
                end
                PH_LRC:
                begin
                    if (b != lrc_reg)
                    begin
                        res_valid  = 1'b1;
                        res_status = lrc_pkg::ST_LRC_ERR;
                        do_clear   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_EOP;
                    end
                end
                PH_EOP:
                begin
                    res_valid = 1'b1;
                    if (b != lrc_pkg::END_BYTE)
                    begin
                        res_status = lrc_pkg::ST_EOP_ERR;
                        do_clear   = 1'b1;
                    end
                    else
                    begin
                        frame_done_next = 1'b1;
                    end
                end
                default:
                begin
                    // first start byte, also any unused phase code
                    phase_next = (b == lrc_pkg::START_BYTE) ? PH_SOP2 : PH_SOP1;
                end
            endcase
        end

        if (do_clear)
        begin
            phase_next        = PH_SOP1;
            lrc_next          = 8'd0;
            held_length_next  = 8'd0;
            held_command_next = 8'd0;
            held_id_next      = 16'd0;
            bytes_left_next   = 8'd0;
            frame_done_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SOP1;
            lrc_reg          <= 8'd0;
            held_length_reg  <= 8'd0;
            held_command_reg <= 8'd0;
            held_id_reg      <= 16'd0;
            bytes_left_reg   <= 8'd0;
            frame_done_reg   <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            phase_reg        <= phase_next;
            lrc_reg          <= lrc_next;
            held_length_reg  <= held_length_next;
            held_command_reg <= held_command_next;
            held_id_reg      <= held_id_next;
            bytes_left_reg   <= bytes_left_next;
            frame_done_reg   <= frame_done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_data_reg <= {4'd0, res_payload, res_length, res_id,
                             res_command_valid, res_command, res_status};
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_kind_reg;
    assign m_axis_tdata    = out_data_reg;

    // payload bytes only come from a frame with a legal command and no error
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == lrc_pkg::KIND_PAYLOAD)
        |-> (m_axis_tdata[2:0] == lrc_pkg::ST_OK) && m_axis_tdata[11]
            && (m_axis_tdata[43:36] == m_axis_tdata[43:36]) && (m_axis_tdata[47:44] == 4'd0))
        else $error("payload result with error status or no command");

    // a payload phase always has bytes still to come
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != 8'd0))
        else $error("payload phase with zero byte count");

    // a good frame parks the parser on its end byte
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_done_reg |-> (phase_reg == PH_EOP))
        else $error("frame done outside end-of-frame phase");

    // length errors never carry a command or an ID
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == lrc_pkg::ST_LEN_ERR)
        |-> !m_axis_tdata[11] && (m_axis_tdata[27:12] == 16'd0)
            && (m_axis_tdata[10:3] == 8'd0))
        else $error("length error result carries frame fields");

    // a rearm request always leaves the parser cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && (in_op_reg == lrc_pkg::OP_REARM)
        |=> (phase_reg == PH_SOP1) && !frame_done_reg && (lrc_reg == 8'd0))
        else $error("rearm did not clear the parser");

endmodule
